// File: rtl/rcf_pkg.sv
// Shared constants, register and mode codes, and the sequencer state type
// for the resonant cascade filter. No dependencies.
package rcf_pkg;

    localparam int CHANNELS   = 8;
    localparam int MAX_STAGES = 8;
    localparam int STRIDE     = MAX_STAGES + 1;
    localparam int DEPTH      = CHANNELS * STRIDE;
    localparam int AW         = $clog2(DEPTH);
    localparam int SW         = $clog2(STRIDE);
    localparam int CMPW       = (SW > 4) ? SW : 4;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 24;
    localparam int STAGE_W  = 32;
    localparam int LEVEL_W  = 17;
    localparam int SC_W     = 4;
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 17;
    localparam int FB_W     = 30;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;
    localparam logic [LEVEL_W-1:0] CUT_CAP   = 17'd65529;
    localparam logic [FB_W-1:0]    FB_RESET  = 30'd613632292;

    localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] REG_CUTOFF    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESONANCE = 3'd2;
    localparam logic [IDX_W-1:0] REG_STAGES    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_LOW     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BAND    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_S0,
        S_RD_S1,
        S_GET_S1,
        S_FB_LO,
        S_FB_HI,
        S_FB_ACC,
        S_D0,
        S_CD_LO,
        S_CD_HI,
        S_CD_ACC,
        S_UPD,
        S_GET,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// File: rtl/rcf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rcf_fb_calc.sv
// Feedback gain unit: r + floor(r * 2^16 / (1.0 - min(c, cap))), one quotient
// bit per cycle with a restoring divider. Depends on rcf_pkg.
module rcf_fb_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rcf_pkg::LEVEL_W-1:0] i_cutoff,
    input  logic [rcf_pkg::LEVEL_W-1:0] i_resonance,
    output logic                        o_busy,
    output logic [rcf_pkg::FB_W-1:0]    o_fb
);

    localparam int NUM_W = rcf_pkg::LEVEL_W + 16;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]            r_num;
    logic [NUM_W-1:0]            r_quo;
    logic [rcf_pkg::LEVEL_W-1:0] r_rem;
    logic [rcf_pkg::LEVEL_W-1:0] r_den;
    logic [rcf_pkg::LEVEL_W-1:0] r_res;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic [rcf_pkg::FB_W-1:0]    r_fb;

    logic [rcf_pkg::LEVEL_W-1:0] cut_capped;
    logic [rcf_pkg::LEVEL_W:0]   trial;
    logic                        take;
    logic [NUM_W-1:0]            quo_next;

    always_comb begin
        cut_capped = (i_cutoff > rcf_pkg::CUT_CAP) ? rcf_pkg::CUT_CAP : i_cutoff;
        trial      = {r_rem, r_num[NUM_W-1]};
        take       = (trial >= {1'b0, r_den});
        quo_next   = {r_quo[NUM_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_fb   <= rcf_pkg::FB_RESET;
        end else if (i_start) begin
            r_num  <= {i_resonance, 16'd0};
            r_quo  <= '0;
            r_rem  <= '0;
            r_den  <= rcf_pkg::LEVEL_ONE - cut_capped;
            r_res  <= i_resonance;
            r_cnt  <= CNT_W'(NUM_W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_rem <= take ? rcf_pkg::LEVEL_W'(trial - {1'b0, r_den})
                          : trial[rcf_pkg::LEVEL_W-1:0];
            r_quo <= quo_next;
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_fb   <= rcf_pkg::FB_W'(NUM_W'(r_res) + quo_next);
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_fb   = r_fb;

endmodule

// File: rtl/resonant_cascade_audio_filter_top.sv
// Resonant cascaded one-pole filter, per-channel stage sets kept in one RAM.
// Depends on rcf_pkg, rcf_ram and rcf_fb_calc.
//
//   channel   handshake                  payload
//   input     i_in_valid / o_in_ready    i_channel, i_sample_in
//   output    o_out_valid / i_out_ready  o_channel_out, o_sample_out, o_clipped
//   config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// A filtered request updates its stages in turn, paced by the single shared
// multiplier and the one-read-per-cycle stage RAM. A bypassed request
// (disabled or unknown channel) goes straight to the done state. Each write
// to a known register starts a gain division; new requests wait for it.
// Reset clears all stages at once through per-entry valid bits.
// A new request is taken while a finished result waits in the output register.
module resonant_cascade_audio_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rcf_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [rcf_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rcf_pkg::CH_W-1:0]            i_channel,
    input  logic signed [rcf_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rcf_pkg::CH_W-1:0]            o_channel_out,
    output logic signed [rcf_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_clipped
);

    localparam int X_W    = rcf_pkg::SAMPLE_W + 1;
    localparam int ACC_W  = 50;
    localparam int D_W    = 48;
    localparam int A_W    = 34;
    localparam int B_W    = 18;
    localparam int PROD_W = A_W + B_W;
    localparam int Y_W    = 34;
    localparam int FB_HI  = rcf_pkg::FB_W - 16;

    localparam logic signed [ACC_W-1:0] D_LIM     = ACC_W'(64'sd70368744177664);
    localparam logic signed [ACC_W-1:0] S_MAX     = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] S_MIN     = ACC_W'(-64'sd2147483648);
    localparam logic signed [Y_W-1:0]   SMP_MAX   = Y_W'(64'sd8388607);
    localparam logic signed [Y_W-1:0]   SMP_MIN   = Y_W'(-64'sd8388608);

    // sequencer and datapath registers
    rcf_pkg::t_state r_state, n_state;
    logic [rcf_pkg::CH_W-1:0]           r_ch;
    logic [rcf_pkg::AW-1:0]             r_base;
    logic [rcf_pkg::SW-1:0]             r_idx;
    logic                               r_bypass;
    logic signed [X_W-1:0]              r_x;
    logic signed [rcf_pkg::STAGE_W-1:0] r_cur;
    logic signed [rcf_pkg::STAGE_W-1:0] r_prev;
    logic signed [rcf_pkg::STAGE_W-1:0] r_first;
    logic signed [ACC_W-1:0]            r_acc;
    logic signed [D_W-1:0]              r_d;
    logic signed [PROD_W-1:0]           r_prod;
    logic                               r_rd_valid;
    logic [rcf_pkg::DEPTH-1:0]          r_valid, n_valid;

    // configuration
    logic [rcf_pkg::MODE_W-1:0]  r_mode;
    logic [rcf_pkg::LEVEL_W-1:0] r_cutoff;
    logic [rcf_pkg::LEVEL_W-1:0] r_resonance;
    logic [rcf_pkg::SC_W-1:0]    r_stage_count;
    logic                        r_enabled;
    logic                        r_fb_start;

    // output register
    logic                                r_out_valid;
    logic [rcf_pkg::CH_W-1:0]            r_channel_out;
    logic signed [rcf_pkg::SAMPLE_W-1:0] r_sample_out;
    logic                                r_clipped;

    logic                               fb_busy;
    logic [rcf_pkg::FB_W-1:0]           fb;
    logic [rcf_pkg::STAGE_W-1:0]        ram_q;
    logic signed [rcf_pkg::STAGE_W-1:0] rd_value;
    logic [rcf_pkg::AW-1:0]             raddr;
    logic [rcf_pkg::AW-1:0]             waddr;
    logic                               ram_we;
    logic signed [A_W-1:0]              mul_a;
    logic signed [B_W-1:0]              mul_b;
    logic signed [ACC_W-1:0]            s_sum;
    logic signed [rcf_pkg::STAGE_W-1:0] s_new;
    logic signed [ACC_W-1:0]            d_full;
    logic signed [D_W-1:0]              d_sat;
    logic signed [Y_W-1:0]              y_src;
    logic signed [Y_W-1:0]              y_half;
    logic signed [rcf_pkg::SAMPLE_W-1:0] y_sat;
    logic                               y_clip;
    logic                               in_ready;
    logic                               accept;
    logic                               out_free;
    logic                               is_last;
    logic                               bypass_in;
    logic                               cfg_hit;
    logic [rcf_pkg::SC_W-1:0]           sc_raw;
    logic [rcf_pkg::SC_W-1:0]           sc_new;
    logic [rcf_pkg::LEVEL_W-1:0]        lvl_new;

    rcf_ram #(
        .WIDTH (rcf_pkg::STAGE_W),
        .DEPTH (rcf_pkg::DEPTH)
    ) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (s_new),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    rcf_fb_calc u_fb_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_fb_start),
        .i_cutoff    (r_cutoff),
        .i_resonance (r_resonance),
        .o_busy      (fb_busy),
        .o_fb        (fb)
    );

    // ---------------- combinational datapath ----------------
    always_comb begin
        rd_value  = r_rd_valid ? $signed(ram_q) : '0;
        accept    = i_in_valid && in_ready;
        out_free  = !r_out_valid || i_out_ready;
        is_last   = (rcf_pkg::CMPW'(r_idx) == rcf_pkg::CMPW'(r_stage_count));
        bypass_in = !r_enabled || (int'(i_channel) >= rcf_pkg::CHANNELS);
        waddr     = r_base + rcf_pkg::AW'(r_idx);

        s_sum = ACC_W'(r_cur) + r_acc;
        if (s_sum > S_MAX) begin
            s_new = rcf_pkg::STAGE_W'(S_MAX);
        end else if (s_sum < S_MIN) begin
            s_new = rcf_pkg::STAGE_W'(S_MIN);
        end else begin
            s_new = rcf_pkg::STAGE_W'(s_sum);
        end

        d_full = ACC_W'(r_x) - ACC_W'(r_cur) + r_acc;
        if (d_full > D_LIM) begin
            d_sat = D_W'(D_LIM);
        end else if (d_full < -D_LIM) begin
            d_sat = D_W'(-D_LIM);
        end else begin
            d_sat = D_W'(d_full);
        end

        if (r_bypass) begin
            y_src = Y_W'(r_x);
        end else begin
            case (r_mode)
                rcf_pkg::MODE_HIGH: y_src = Y_W'(r_x) - Y_W'(r_prev);
                rcf_pkg::MODE_BAND: y_src = Y_W'(r_first) - Y_W'(r_prev);
                default:            y_src = Y_W'(r_prev);
            endcase
        end
        y_half = y_src >>> 1;
        if (y_half > SMP_MAX) begin
            y_sat  = rcf_pkg::SAMPLE_W'(SMP_MAX);
            y_clip = 1'b1;
        end else if (y_half < SMP_MIN) begin
            y_sat  = rcf_pkg::SAMPLE_W'(SMP_MIN);
            y_clip = 1'b1;
        end else begin
            y_sat  = rcf_pkg::SAMPLE_W'(y_half);
            y_clip = 1'b0;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcf_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = bypass_in ? rcf_pkg::S_DONE : rcf_pkg::S_RD_S0;
                end
            end
            rcf_pkg::S_RD_S0:  n_state = rcf_pkg::S_RD_S1;
            rcf_pkg::S_RD_S1:  n_state = rcf_pkg::S_GET_S1;
            rcf_pkg::S_GET_S1: n_state = rcf_pkg::S_FB_LO;
            rcf_pkg::S_FB_LO:  n_state = rcf_pkg::S_FB_HI;
            rcf_pkg::S_FB_HI:  n_state = rcf_pkg::S_FB_ACC;
            rcf_pkg::S_FB_ACC: n_state = rcf_pkg::S_D0;
            rcf_pkg::S_D0:     n_state = rcf_pkg::S_CD_LO;
            rcf_pkg::S_CD_LO:  n_state = rcf_pkg::S_CD_HI;
            rcf_pkg::S_CD_HI:  n_state = rcf_pkg::S_CD_ACC;
            rcf_pkg::S_CD_ACC: n_state = rcf_pkg::S_UPD;
            rcf_pkg::S_UPD:    n_state = is_last ? rcf_pkg::S_DONE : rcf_pkg::S_GET;
            rcf_pkg::S_GET:    n_state = rcf_pkg::S_MUL;
            rcf_pkg::S_MUL:    n_state = rcf_pkg::S_ACC;
            rcf_pkg::S_ACC:    n_state = rcf_pkg::S_UPD;
            rcf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = rcf_pkg::S_IDLE;
                end
            end
            default: n_state = rcf_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        in_ready = 1'b0;
        ram_we   = 1'b0;
        raddr    = r_base;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            rcf_pkg::S_IDLE:  in_ready = !fb_busy && !r_fb_start;
            rcf_pkg::S_RD_S1: raddr = r_base + rcf_pkg::AW'(1);
            rcf_pkg::S_FB_LO: begin
                mul_a = A_W'(r_cur) - A_W'(r_prev);
                mul_b = $signed({2'b00, fb[15:0]});
            end
            rcf_pkg::S_FB_HI: begin
                mul_a = A_W'(r_cur) - A_W'(r_prev);
                mul_b = $signed({(B_W - FB_HI)'(0), fb[rcf_pkg::FB_W-1:16]});
            end
            rcf_pkg::S_CD_LO: begin
                mul_a = $signed({(A_W - 16)'(0), r_d[15:0]});
                mul_b = $signed({1'b0, r_cutoff});
            end
            rcf_pkg::S_CD_HI: begin
                mul_a = A_W'($signed(r_d[D_W-1:16]));
                mul_b = $signed({1'b0, r_cutoff});
            end
            rcf_pkg::S_MUL: begin
                mul_a = A_W'(r_prev) - A_W'(r_cur);
                mul_b = $signed({1'b0, r_cutoff});
            end
            rcf_pkg::S_UPD: begin
                ram_we = 1'b1;
                // prefetch the next stage while writing this one back
                if (!is_last) begin
                    raddr = waddr + rcf_pkg::AW'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod     <= mul_a * mul_b;
        r_rd_valid <= r_valid[raddr];
        unique case (r_state)
            rcf_pkg::S_IDLE: begin
                if (accept) begin
                    r_ch     <= i_channel;
                    r_x      <= X_W'(i_sample_in) <<< 1;
                    r_bypass <= bypass_in;
                    r_base   <= rcf_pkg::AW'(int'(i_channel) * rcf_pkg::STRIDE);
                    r_idx    <= '0;
                end
            end
            rcf_pkg::S_RD_S1:  r_cur  <= rd_value;
            rcf_pkg::S_GET_S1: r_prev <= rd_value;
            rcf_pkg::S_FB_HI:  r_acc  <= ACC_W'(r_prod >>> 16);
            rcf_pkg::S_FB_ACC: r_acc  <= r_acc + ACC_W'(r_prod);
            rcf_pkg::S_D0:     r_d    <= d_sat;
            rcf_pkg::S_CD_HI:  r_acc  <= ACC_W'(r_prod >>> 16);
            rcf_pkg::S_CD_ACC: r_acc  <= r_acc + ACC_W'(r_prod);
            rcf_pkg::S_UPD: begin
                r_prev <= s_new;
                if (r_idx == '0) begin
                    r_first <= s_new;
                end
                if (!is_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            rcf_pkg::S_GET: r_cur <= rd_value;
            rcf_pkg::S_ACC: r_acc <= ACC_W'(r_prod >>> 16);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration ----------------
    always_comb begin
        sc_raw  = i_cfg_data[rcf_pkg::SC_W-1:0];
        lvl_new = (i_cfg_data[rcf_pkg::LEVEL_W-1:0] > rcf_pkg::LEVEL_ONE)
                  ? rcf_pkg::LEVEL_ONE : i_cfg_data[rcf_pkg::LEVEL_W-1:0];
        if (sc_raw == '0) begin
            sc_new = rcf_pkg::SC_W'(1);
        end else if (int'(sc_raw) > rcf_pkg::MAX_STAGES) begin
            sc_new = rcf_pkg::SC_W'(rcf_pkg::MAX_STAGES);
        end else begin
            sc_new = sc_raw;
        end
        unique case (i_cfg_index)
            rcf_pkg::REG_MODE, rcf_pkg::REG_CUTOFF, rcf_pkg::REG_RESONANCE,
            rcf_pkg::REG_STAGES, rcf_pkg::REG_ENABLE: cfg_hit = i_cfg_we;
            default:                                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rcf_pkg::MODE_LOW;
            r_cutoff      <= rcf_pkg::LEVEL_ONE;
            r_resonance   <= rcf_pkg::LEVEL_ONE;
            r_stage_count <= rcf_pkg::SC_W'(1);
            r_enabled     <= 1'b1;
            r_fb_start    <= 1'b0;
        end else begin
            // rederive the gain the cycle after any known register is written
            r_fb_start <= cfg_hit;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rcf_pkg::REG_MODE: begin
                        if (i_cfg_data[rcf_pkg::MODE_W-1:0] != rcf_pkg::MODE_INVALID) begin
                            r_mode <= i_cfg_data[rcf_pkg::MODE_W-1:0];
                        end
                    end
                    rcf_pkg::REG_CUTOFF:    r_cutoff      <= lvl_new;
                    rcf_pkg::REG_RESONANCE: r_resonance   <= lvl_new;
                    rcf_pkg::REG_STAGES:    r_stage_count <= sc_new;
                    rcf_pkg::REG_ENABLE:    r_enabled     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // stage valid bits: an entry that is not valid reads as zero
    always_comb begin
        n_valid = r_valid;
        if (ram_we) begin
            n_valid[waddr] = 1'b1;
        end
        if (i_cfg_we) begin
            case (i_cfg_index)
                rcf_pkg::REG_STAGES: begin
                    for (int ch = 0; ch < rcf_pkg::CHANNELS; ch++) begin
                        for (int b = 0; b < rcf_pkg::STRIDE; b++) begin
                            if (b > int'(r_stage_count) && b <= int'(sc_new)) begin
                                n_valid[ch * rcf_pkg::STRIDE + b] = 1'b0;
                            end
                        end
                    end
                end
                rcf_pkg::REG_ENABLE: begin
                    if (!i_cfg_data[0]) begin
                        n_valid = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == rcf_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rcf_pkg::S_DONE && out_free) begin
            r_channel_out <= r_ch;
            r_sample_out  <= y_sat;
            r_clipped     <= y_clip;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_channel_out;
    assign o_sample_out  = r_sample_out;
    assign o_clipped     = r_clipped;

endmodule

// File: tb/sv/resonant_cascade_audio_filter_top_test.sv
// Self-checking testbench for resonant_cascade_audio_filter_top: sends
// channel-tagged samples, writes the registers between bursts, predicts every
// filtered sample and checks results in order. Depends on rcf_pkg and the RTL.
`timescale 1ns / 1ps

module resonant_cascade_audio_filter_top_test;
    import rcf_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filtered_t;

    localparam longint STAGE_MAX = (64'sd1 <<< 31) - 1;
    localparam longint STAGE_MIN = -(64'sd1 <<< 31);
    localparam longint STEP_LIMIT = 64'sd1 <<< 46;
    localparam longint OUT_MAX = (64'sd1 <<< 23) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< 23);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam int END_WAIT = 64;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [IDX_W-1:0]           i_cfg_index = '0;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [CH_W-1:0]            i_channel = '0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [CH_W-1:0]            o_channel_out;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_clipped;

    // mirrored filter state and registers
    logic signed [STAGE_W-1:0] stage_acc [CHANNELS][STRIDE];
    logic [MODE_W-1:0]  mode_r;
    logic [LEVEL_W-1:0] cutoff_r;
    logic [LEVEL_W-1:0] resonance_r;
    logic [SC_W-1:0]    stages_r;
    logic               enabled_r;
    longint             gain_r;

    filtered_t expected_samples[$];
    int        mismatch_count = 0;
    bit        gaps_on = 1'b1;
    int        hold_off_req = 0;
    int        walk_level [CHANNELS];

    resonant_cascade_audio_filter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel     (i_channel),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out),
        .o_clipped     (o_clipped)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void update_gain();
        longint c;
        longint r;
        c = (cutoff_r > CUT_CAP) ? longint'(CUT_CAP) : longint'(cutoff_r);
        r = resonance_r;
        gain_r = r + ((r << 16) / (65536 - c));
    endfunction

    function automatic void clear_stages(input int from, input int upto);
        int ch;
        int b;
        for (ch = 0; ch < CHANNELS; ch++)
            for (b = from; b < upto && b < STRIDE; b++)
                stage_acc[ch][b] = '0;
    endfunction

    function automatic void reset_filter_state();
        clear_stages(0, STRIDE);
        mode_r      = MODE_LOW;
        cutoff_r    = LEVEL_ONE;
        resonance_r = LEVEL_ONE;
        stages_r    = 1;
        enabled_r   = 1'b1;
        update_gain();
    endfunction

    function automatic void apply_write(input logic [IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
        logic [SC_W-1:0] count;
        case (idx)
            REG_MODE: if (data[MODE_W-1:0] != MODE_INVALID) mode_r = data[MODE_W-1:0];
            REG_CUTOFF:    cutoff_r = (data > LEVEL_ONE) ? LEVEL_ONE : data;
            REG_RESONANCE: resonance_r = (data > LEVEL_ONE) ? LEVEL_ONE : data;
            REG_STAGES: begin
                count = data[SC_W-1:0];
                if (count < 1) count = 1;
                if (count > MAX_STAGES) count = MAX_STAGES;
                // stages that come into use start from zero
                if (count > stages_r) clear_stages(stages_r + 1, count + 1);
                stages_r = count;
            end
            REG_ENABLE: begin
                enabled_r = data[0];
                if (!enabled_r) clear_stages(0, STRIDE);
            end
            default: return;
        endcase
        update_gain();
    endfunction

    // Advance one channel's cascade by one sample and form the output.
    function automatic filtered_t filter_sample(input logic [CH_W-1:0] ch,
                                                input logic signed [SAMPLE_W-1:0] smp);
        filtered_t res;
        longint x;
        longint d;
        longint y;
        longint c;
        longint prev;
        longint cur;
        int last;
        int b;
        res.channel = ch;
        res.sample  = smp;
        res.clipped = 1'b0;
        if (!enabled_r || ch >= CHANNELS) return res;
        last = stages_r;
        c    = cutoff_r;
        x    = longint'(smp) * 2;
        prev = stage_acc[ch][0];
        cur  = stage_acc[ch][1];
        d = (x - prev) + ((gain_r * (prev - cur)) >>> 16);
        d = clamp(d, -STEP_LIMIT, STEP_LIMIT);
        stage_acc[ch][0] = clamp(prev + ((c * d) >>> 16), STAGE_MIN, STAGE_MAX);
        for (b = 1; b <= last; b++) begin
            prev = stage_acc[ch][b-1];
            cur  = stage_acc[ch][b];
            stage_acc[ch][b] = clamp(cur + ((c * (prev - cur)) >>> 16), STAGE_MIN, STAGE_MAX);
        end
        case (mode_r)
            MODE_HIGH: y = x - longint'(stage_acc[ch][last]);
            MODE_BAND: y = longint'(stage_acc[ch][0]) - longint'(stage_acc[ch][last]);
            default:   y = longint'(stage_acc[ch][last]);
        endcase
        y = y >>> 1;
        if (y > OUT_MAX || y < OUT_MIN) res.clipped = 1'b1;
        y = clamp(y, OUT_MIN, OUT_MAX);
        res.sample = y[SAMPLE_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Mostly smooth per-channel audio, with full-scale noise and rail values mixed in.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(input logic [CH_W-1:0] ch);
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                walk_level[ch] = clamp(longint'(walk_level[ch]) +
                                       $urandom_range(0, 131072) - 65536, OUT_MIN, OUT_MAX);
                v = walk_level[ch];
            end
            5, 6, 7: v = $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0: v = SAMPLE_MAX;
                    1: v = SAMPLE_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = int'($urandom_range(0, 511)) - 256;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_level(input int typical_max);
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = LEVEL_ONE;
            2: v = $urandom_range(LEVEL_ONE + 1, (1 << CFG_W) - 1);
            3: v = CUT_CAP;
            default: v = $urandom_range(1, typical_max);
        endcase
        return v;
    endfunction

    task automatic idle_input(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [CH_W-1:0] ch,
                                input logic signed [SAMPLE_W-1:0] smp);
        i_in_valid  <= 1'b1;
        i_channel   <= ch;
        i_sample_in <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        expected_samples.push_back(filter_sample(ch, smp));
    endtask

    task automatic send_and_idle(input logic [CH_W-1:0] ch,
                                 input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        send_request(ch, smp);
        gap = pick_gap();
        if (gap > 0) idle_input(gap);
    endtask

    // Drop valid and hold until every outstanding request has its result.
    task automatic finish_phase();
        idle_input(1);
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_write(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_and_idle(0, SAMPLE_MAX);
        send_and_idle(1, SAMPLE_MIN);
        send_and_idle(2, '0);
        send_and_idle(3, '1);
    endtask

    task automatic test_filter_modes();
        logic [MODE_W-1:0] m;
        finish_phase();
        write_reg(REG_CUTOFF, 32768);
        write_reg(REG_RESONANCE, 16384);
        write_reg(REG_STAGES, 2);
        for (m = MODE_LOW; m <= MODE_BAND; m++) begin
            finish_phase();
            write_reg(REG_MODE, m);
            send_and_idle(4, SAMPLE_MAX);
            send_and_idle(5, SAMPLE_MIN);
        end
        // invalid mode code leaves band-pass in place
        finish_phase();
        write_reg(REG_MODE, MODE_INVALID);
        send_and_idle(4, 24'sh123456);
    endtask

    task automatic test_register_limits();
        logic [IDX_W-1:0] idx;
        finish_phase();
        write_reg(REG_CUTOFF, '1);
        write_reg(REG_RESONANCE, '1);
        send_and_idle(6, 24'sh400000);
        finish_phase();
        write_reg(REG_STAGES, 0);
        send_and_idle(6, 24'shC00000);
        finish_phase();
        write_reg(REG_STAGES, '1);
        send_and_idle(7, 24'sh200000);
        finish_phase();
        for (idx = REG_ENABLE + 1; idx != 0; idx++) write_reg(idx, $urandom);
        write_reg(REG_STAGES, 17'h10);
        send_and_idle(7, 24'shE00000);
    endtask

    task automatic test_stage_resize();
        finish_phase();
        write_reg(REG_CUTOFF, 40000);
        write_reg(REG_RESONANCE, 8000);
        write_reg(REG_STAGES, MAX_STAGES);
        send_and_idle(6, SAMPLE_MAX);
        send_and_idle(6, SAMPLE_MAX);
        finish_phase();
        write_reg(REG_STAGES, 2);
        send_and_idle(6, SAMPLE_MAX);
        finish_phase();
        write_reg(REG_STAGES, 6);
        send_and_idle(6, SAMPLE_MIN);
    endtask

    task automatic test_bypass();
        finish_phase();
        write_reg(REG_ENABLE, 0);
        send_and_idle(7, SAMPLE_MAX);
        send_and_idle(0, SAMPLE_MIN);
        finish_phase();
        write_reg(REG_ENABLE, 1);
        send_and_idle(7, 24'sh000100);
    endtask

    task automatic test_corner_settings();
        int corner;
        int k;
        logic [CH_W-1:0] ch;
        for (corner = 0; corner < 6; corner++) begin
            finish_phase();
            case (corner)
                0: begin
                    write_reg(REG_MODE, MODE_LOW);
                    write_reg(REG_CUTOFF, 0);
                    write_reg(REG_RESONANCE, 0);
                    write_reg(REG_STAGES, 1);
                end
                1: begin
                    write_reg(REG_MODE, MODE_HIGH);
                    write_reg(REG_CUTOFF, LEVEL_ONE);
                    write_reg(REG_RESONANCE, 0);
                    write_reg(REG_STAGES, MAX_STAGES);
                end
                2: begin
                    write_reg(REG_MODE, MODE_BAND);
                    write_reg(REG_CUTOFF, CUT_CAP);
                    write_reg(REG_RESONANCE, LEVEL_ONE);
                    write_reg(REG_STAGES, MAX_STAGES);
                end
                3: begin
                    write_reg(REG_MODE, MODE_LOW);
                    write_reg(REG_CUTOFF, 1);
                    write_reg(REG_RESONANCE, LEVEL_ONE);
                    write_reg(REG_STAGES, 1);
                end
                4: begin
                    write_reg(REG_MODE, MODE_HIGH);
                    write_reg(REG_CUTOFF, 20000);
                    write_reg(REG_RESONANCE, 40000);
                    write_reg(REG_STAGES, 4);
                end
                default: begin
                    write_reg(REG_MODE, MODE_BAND);
                    write_reg(REG_CUTOFF, LEVEL_ONE);
                    write_reg(REG_RESONANCE, LEVEL_ONE);
                    write_reg(REG_STAGES, 1);
                end
            endcase
            write_reg(REG_ENABLE, 0);
            write_reg(REG_ENABLE, 1);
            for (k = 0; k < 30; k++) begin
                ch = $urandom_range(0, CHANNELS - 1);
                send_and_idle(ch, next_sample(ch));
            end
        end
    endtask

    // Stall the output long enough that the block backs up into the input.
    task automatic test_output_hold_off();
        int k;
        logic [CH_W-1:0] ch;
        finish_phase();
        gaps_on = 1'b0;
        hold_off_req = 400;
        for (k = 0; k < 60; k++) begin
            ch = $urandom_range(0, CHANNELS - 1);
            send_request(ch, next_sample(ch));
        end
        finish_phase();
        gaps_on = 1'b1;
    endtask

    task automatic randomize_settings();
        logic [IDX_W-1:0] idx;
        if ($urandom_range(0, 1)) write_reg(REG_MODE, $urandom);
        if ($urandom_range(0, 1)) write_reg(REG_CUTOFF, pick_level(LEVEL_ONE - 1));
        if ($urandom_range(0, 1)) write_reg(REG_RESONANCE, pick_level(30000));
        if ($urandom_range(0, 1)) write_reg(REG_STAGES, $urandom);
        if (!enabled_r) begin
            write_reg(REG_ENABLE, {16'($urandom), 1'b1});
        end else begin
            case ($urandom_range(0, 5))
                0: write_reg(REG_ENABLE, {16'($urandom), 1'b0});
                1: begin
                    write_reg(REG_ENABLE, 0);
                    write_reg(REG_ENABLE, 1);
                end
                2: write_reg(REG_ENABLE, 1);
                default: ;
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            idx = $urandom_range(REG_ENABLE + 1, (1 << IDX_W) - 1);
            write_reg(idx, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int k;
        logic [CH_W-1:0] ch;
        for (phase = 0; phase < 14; phase++) begin
            finish_phase();
            randomize_settings();
            gaps_on = ($urandom_range(0, 3) != 0);
            for (k = 0; k < 85; k++) begin
                ch = $urandom_range(0, CHANNELS - 1);
                send_and_idle(ch, next_sample(ch));
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin : out_side
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                stall = hold_off_req;
                hold_off_req = 0;
            end else if (stall == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        filtered_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("result with nothing outstanding: channel_out %0d sample_out %0d",
                       o_channel_out, o_sample_out);
                mismatch_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_channel_out !== want.channel) begin
                    $error("channel_out: expected %0d, got %0d", want.channel, o_channel_out);
                    mismatch_count++;
                end
                if (o_sample_out !== want.sample) begin
                    $error("sample_out: expected %0d, got %0d", want.sample, o_sample_out);
                    mismatch_count++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped, o_clipped);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        reset_filter_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_filter_modes();
        test_register_limits();
        test_stage_resize();
        test_bypass();
        test_corner_settings();
        test_output_hold_off();
        test_random_traffic();
        finish_phase();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/rcf_pkg.sv
rtl/rcf_ram.sv
rtl/rcf_fb_calc.sv
rtl/resonant_cascade_audio_filter_top.sv
tb/sv/resonant_cascade_audio_filter_top_test.sv
